// ===== rtl/core/rsb_pkg.sv =====
// shared types and constants for the run-length sprite blitter
package rsb_pkg;

    localparam int ADDR_BITS  = 20;
    localparam int PIXEL_BITS = 16;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP1  = 3'd1,
        PH_SKIP2  = 3'd2,
        PH_COUNT  = 3'd3,
        PH_RUN    = 3'd4,
        PH_PIXEL  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CFG_LINE_WIDTH  = 3'd0,
        CFG_CLIP_LEFT   = 3'd1,
        CFG_CLIP_RIGHT  = 3'd2,
        CFG_CLIP_TOP    = 3'd3,
        CFG_CLIP_BOTTOM = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]        stream_word;
        logic               sprite_start;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic               mirror;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  write_addr;
        logic [PIXEL_BITS-1:0] write_data;
    } out_item_t;

    // one visible pixel handed from the parser to the address stage
    typedef struct packed {
        logic signed [11:0]    row;
        logic signed [11:0]    col;
        logic [PIXEL_BITS-1:0] data;
    } pix_cmd_t;

    typedef struct packed {
        logic [10:0] line_width;
        logic [10:0] clip_left;
        logic [10:0] clip_right;
        logic [9:0]  clip_top;
        logic [9:0]  clip_bottom;
    } cfg_t;

    // saturate a 14-bit signed sum to 12 bits
    function automatic logic signed [11:0] sat12(input logic signed [13:0] v);
        logic signed [11:0] r;
        if (v > 14'sd2047)
            r = 12'sd2047;
        else if (v < -14'sd2048)
            r = -12'sd2048;
        else
            r = v[11:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/rsb_front.sv =====
// stream parser: tracks the sprite format and emits visible pixel commands
module rsb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  rsb_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  rsb_pkg::in_item_t in_item,
    output logic              cmd_valid,
    input  logic              cmd_stall,
    output rsb_pkg::pix_cmd_t cmd
);
    import rsb_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         lines_reg, lines_next;
    logic [7:0]         runs_reg, runs_next;
    logic [7:0]         pix_reg, pix_next;
    logic signed [11:0] row_reg, row_next;
    logic signed [11:0] col_reg, col_next;
    logic signed [11:0] org_reg, org_next;
    logic               mir_reg, mir_next;
    logic               rej_reg, rej_next;
    logic               take;
    logic               vis;

    // visible when the sprite is not rejected and the pen is inside the clip rectangle
    always_comb
    begin
        vis = !rej_reg
            && (row_reg >= $signed({2'b00, cfg.clip_top}))
            && (row_reg <= $signed({2'b00, cfg.clip_bottom}))
            && (col_reg >= $signed({1'b0, cfg.clip_left}))
            && (col_reg <  $signed({1'b0, cfg.clip_right}));
    end

    assign in_stall = cmd_stall;
    assign take     = in_valid && !cmd_stall;

    // parser next state
    always_comb
    begin
        logic signed [13:0] x, y, w, h, skip;
        logic               rej;
        phase_t             after_line;
        logic [7:0]         lines_dec;
        x          = 14'(in_item.pos_x);
        y          = 14'(in_item.pos_y);
        w          = {6'd0, in_item.stream_word[7:0]};
        h          = {6'd0, in_item.stream_word[15:8]};
        skip       = {6'd0, in_item.stream_word[7:0]};
        rej        = 1'b0;
        lines_dec  = lines_reg - 8'd1;
        after_line = (lines_dec == 8'd0) ? PH_HEADER : PH_COUNT;
        phase_next = phase_reg;
        lines_next = lines_reg;
        runs_next  = runs_reg;
        pix_next   = pix_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        org_next   = org_reg;
        mir_next   = mir_reg;
        rej_next   = rej_reg;
        if (take)
        begin
            if (in_item.sprite_start)
            begin
                lines_next = in_item.stream_word[15:8];
                mir_next   = in_item.mirror;
                row_next   = in_item.pos_y;
                org_next   = in_item.mirror ? sat12(x + w - 14'sd1) : in_item.pos_x;
                col_next   = org_next;
                if (y > $signed({4'd0, cfg.clip_bottom})
                    || y + h < $signed({4'd0, cfg.clip_top}))
                    rej = 1'b1;
                if (in_item.mirror)
                begin
                    if (!(x >= $signed({3'd0, cfg.clip_left})
                          && x + w < $signed({3'd0, cfg.clip_right})))
                        rej = 1'b1;
                end
                else if (x < $signed({3'd0, cfg.clip_left}) - w
                         || x > $signed({3'd0, cfg.clip_right}))
                    rej = 1'b1;
                rej_next   = rej;
                phase_next = PH_SKIP1;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER: phase_next = PH_HEADER;
                    PH_SKIP1:  phase_next = PH_SKIP2;
                    PH_SKIP2:  phase_next = (lines_reg == 8'd0) ? PH_HEADER : PH_COUNT;
                    PH_COUNT:
                    begin
                        runs_next = in_item.stream_word[7:0];
                        col_next  = org_reg;
                        if (runs_next == 8'd0)
                        begin
                            row_next   = sat12(14'(row_reg) + 14'sd1);
                            lines_next = lines_dec;
                            phase_next = after_line;
                        end
                        else
                            phase_next = PH_RUN;
                    end
                    PH_RUN:
                    begin
                        col_next  = sat12(mir_reg ? 14'(col_reg) - skip
                                                  : 14'(col_reg) + skip);
                        pix_next  = in_item.stream_word[15:8];
                        runs_next = runs_reg - 8'd1;
                        if (pix_next != 8'd0)
                            phase_next = PH_PIXEL;
                        else if (runs_next != 8'd0)
                            phase_next = PH_RUN;
                        else
                        begin
                            row_next   = sat12(14'(row_reg) + 14'sd1);
                            lines_next = lines_dec;
                            phase_next = after_line;
                        end
                    end
                    PH_PIXEL:
                    begin
                        col_next = sat12(mir_reg ? 14'(col_reg) - 14'sd1
                                                 : 14'(col_reg) + 14'sd1);
                        pix_next = pix_reg - 8'd1;
                        if (pix_next == 8'd0)
                        begin
                            if (runs_reg != 8'd0)
                                phase_next = PH_RUN;
                            else
                            begin
                                row_next   = sat12(14'(row_reg) + 14'sd1);
                                lines_next = lines_dec;
                                phase_next = after_line;
                            end
                        end
                    end
                    default: phase_next = PH_HEADER;
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lines_reg <= '0;
            runs_reg  <= '0;
            pix_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            org_reg   <= '0;
            mir_reg   <= 1'b0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            lines_reg <= lines_next;
            runs_reg  <= runs_next;
            pix_reg   <= pix_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            org_reg   <= org_next;
            mir_reg   <= mir_next;
            rej_reg   <= rej_next;
        end
    end

    // pixel command toward the queue
    always_comb
    begin
        cmd_valid = in_valid && !in_item.sprite_start && phase_reg == PH_PIXEL && vis;
        cmd.row   = row_reg;
        cmd.col   = col_reg;
        cmd.data  = in_item.stream_word[PIXEL_BITS-1:0];
    end

    a_pix_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> phase_reg == PH_PIXEL)
        else $error("pixel command outside pixel phase");
    a_nonzero_px: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXEL |-> pix_reg != 8'd0)
        else $error("pixel phase with empty run");
    a_rej_silent: assert property (@(posedge clk) disable iff (!rst_n)
        rej_reg |-> !cmd_valid)
        else $error("rejected sprite wrote a pixel");
endmodule

// ===== rtl/core/rsb_queue.sv =====
// two-entry queue between parser and address stage
module rsb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_stall,
    input  rsb_pkg::pix_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_stall,
    output rsb_pkg::pix_cmd_t rd_data
);
    import rsb_pkg::*;

    pix_cmd_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    // pointer update
    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_ptr_eq: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers out of step");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && rd_stall) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
endmodule

// ===== rtl/core/rsb_back.sv =====
// address stage: row times stride plus column, registered output
module rsb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsb_pkg::cfg_t        cfg,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  rsb_pkg::pix_cmd_t    cmd,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rsb_pkg::out_item_t   out_item
);
    import rsb_pkg::*;

    logic               valid_reg, valid_next;
    out_item_t          item_reg, item_next;
    logic [21:0]        prod;

    assign cmd_stall = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // visible rows are nonnegative and below 1024, visible columns nonnegative and below 2047
    always_comb
    begin
        prod       = 22'(cmd.row[10:0] * cfg.line_width) + 22'(cmd.col[10:0]);
        valid_next = cmd_stall ? valid_reg : cmd_valid;
        item_next  = item_reg;
        if (!cmd_stall && cmd_valid)
        begin
            item_next.write_addr = prod[ADDR_BITS-1:0];
            item_next.write_data = cmd.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> valid_reg && $stable(item_reg))
        else $error("stalled result changed");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> valid_reg)
        else $error("accepted command not shown");
    a_vis: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !cmd.row[11] && !cmd.col[11])
        else $error("negative position reached address stage");
endmodule

// ===== rtl/core/rle_sprite_clip_blitter.sv =====
// top level of the run-length sprite blitter with clipping
//
// Usage: sprite stream words enter on the in channel (in_valid/in_stall,
// payload in_item), one word per transfer. A word with sprite_start set is a
// header and also carries pos_x, pos_y and mirror. Framebuffer writes leave on
// the out channel (out_valid/out_stall, payload out_item).
// Throughput: one stream word per cycle while in_stall is low; each word updates
// the parser counters and at most one write results.
// Path: a visible pixel transfer is registered in the queue and then in the
// address multiply stage before it shows as a write.
// Configuration: cfg_we/cfg_index/cfg_data write line_width and clip limits;
// write only while the block is idle.
// Reset: parser waits for a header, queue and output are empty, registers take
// line width 320 and clip rectangle 0..319 by 0..239.
// Stall: when out_stall holds, the output register keeps its write, the queue
// fills, and in_stall rises once the queue is full.
module rle_sprite_clip_blitter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  rsb_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output rsb_pkg::out_item_t out_item
);
    import rsb_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     f_valid, f_stall, q_valid, q_stall;
    pix_cmd_t f_cmd, q_cmd;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH:  cfg_next.line_width  = cfg_data;
                CFG_CLIP_LEFT:   cfg_next.clip_left   = cfg_data;
                CFG_CLIP_RIGHT:  cfg_next.clip_right  = cfg_data;
                CFG_CLIP_TOP:    cfg_next.clip_top    = cfg_data[9:0];
                CFG_CLIP_BOTTOM: cfg_next.clip_bottom = cfg_data[9:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width  <= 11'd320;
            cfg_reg.clip_left   <= 11'd0;
            cfg_reg.clip_right  <= 11'd320;
            cfg_reg.clip_top    <= 10'd0;
            cfg_reg.clip_bottom <= 10'd239;
        end
        else
            cfg_reg <= cfg_next;
    end

    rsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cmd_valid (f_valid),
        .cmd_stall (f_stall),
        .cmd       (f_cmd)
    );

    rsb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_stall (q_stall),
        .rd_data  (q_cmd)
    );

    rsb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd_stall (q_stall),
        .cmd       (q_cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );
endmodule
